>>> rtl/u2a_pkg.sv
`timescale 1ns / 1ps

package u2a_pkg;

    localparam int INDEX_WIDTH_DEF = 32;
    localparam int SRC_W           = 32;
    localparam int MAX_RES         = 5;
    localparam int CNT_W           = 3;

    localparam logic [7:0] LEAD_E2 = 8'he2;
    localparam logic [7:0] LEAD_C2 = 8'hc2;
    localparam logic [7:0] LEAD_EF = 8'hef;

    typedef struct packed {
        logic [7:0]       data;
        logic [SRC_W-1:0] src;
        logic             marker;
    } item_t;

    typedef item_t [MAX_RES-1:0] item_list_t;

    typedef struct packed {
        item_list_t       items;
        logic [CNT_W-1:0] count;
    } step_res_t;

    // replacement text, first character in the top byte
    typedef struct packed {
        logic        hit;
        logic [2:0]  len;
        logic [31:0] text;
    } rep_t;

    function automatic rep_t mk_rep(input logic [2:0] len, input logic [31:0] s);
        rep_t r;
        r.hit  = 1'b1;
        r.len  = len;
        r.text = s << (8 * (4 - int'(len)));
        return r;
    endfunction

    function automatic item_t mk_item(input logic [7:0] data, input logic [SRC_W-1:0] src,
                                      input logic marker);
        item_t it;
        it.data   = data;
        it.src    = src;
        it.marker = marker;
        return it;
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return (b == LEAD_E2) || (b == LEAD_C2) || (b == LEAD_EF);
    endfunction

    function automatic logic is_prefix2(input logic [7:0] h0, input logic [7:0] b);
        logic r;
        case (b)
            8'h80, 8'h84, 8'h86, 8'h88, 8'h89, 8'h9a, 8'h9c: r = (h0 == LEAD_E2);
            8'hbb:                                           r = (h0 == LEAD_EF);
            default:                                         r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic rep_t rep2(input logic [7:0] h0, input logic [7:0] b);
        rep_t r;
        r = '0;
        if (h0 == LEAD_C2) begin
            case (b)
                8'hab:   r = mk_rep(3'd2, "<<");
                8'hbb:   r = mk_rep(3'd2, ">>");
                8'ha9:   r = mk_rep(3'd3, "(C)");
                8'hae:   r = mk_rep(3'd3, "(R)");
                8'ha0:   r = mk_rep(3'd1, " ");
                8'had:   r = mk_rep(3'd0, 32'd0);
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    function automatic rep_t rep3(input logic [7:0] h0, input logic [7:0] h1,
                                  input logic [7:0] b);
        rep_t r;
        unique case ({h0, h1, b})
            24'he28094: r = mk_rep(3'd2, "--");
            24'he28093: r = mk_rep(3'd1, "-");
            24'he28090: r = mk_rep(3'd1, "-");
            24'he28091: r = mk_rep(3'd1, "-");
            24'he28092: r = mk_rep(3'd1, "-");
            24'he28098: r = mk_rep(3'd1, "'");
            24'he28099: r = mk_rep(3'd1, "'");
            24'he2809a: r = mk_rep(3'd1, ",");
            24'he2809b: r = mk_rep(3'd1, "'");
            24'he2809c: r = mk_rep(3'd1, "\"");
            24'he2809d: r = mk_rep(3'd1, "\"");
            24'he2809e: r = mk_rep(3'd1, "\"");
            24'he2809f: r = mk_rep(3'd1, "\"");
            24'he280a6: r = mk_rep(3'd3, "...");
            24'he280a2: r = mk_rep(3'd1, "*");
            24'he280a3: r = mk_rep(3'd1, "*");
            24'he280b9: r = mk_rep(3'd1, "<");
            24'he280ba: r = mk_rep(3'd1, ">");
            24'he28690: r = mk_rep(3'd2, "<-");
            24'he28692: r = mk_rep(3'd2, "->");
            24'he28691: r = mk_rep(3'd1, "^");
            24'he28693: r = mk_rep(3'd1, "v");
            24'he28694: r = mk_rep(3'd3, "<->");
            24'he28892: r = mk_rep(3'd1, "-");
            24'he28988: r = mk_rep(3'd1, "~");
            24'he289a0: r = mk_rep(3'd2, "!=");
            24'he289a4: r = mk_rep(3'd2, "<=");
            24'he289a5: r = mk_rep(3'd2, ">=");
            24'he29c85: r = mk_rep(3'd3, "[x]");
            24'he29c93: r = mk_rep(3'd3, "[x]");
            24'he29c94: r = mk_rep(3'd3, "[x]");
            24'he29c97: r = mk_rep(3'd3, "[ ]");
            24'he29aa0: r = mk_rep(3'd3, "(!)");
            24'he284a2: r = mk_rep(3'd4, "(TM)");
            24'hefbbbf: r = mk_rep(3'd0, 32'd0);
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/utf8_punctuation_to_ascii_unit.sv
`timescale 1ns / 1ps

// utf8 punctuation to ascii normalizer
// s_axis carries the text one byte per transfer, tlast on the final byte of a text.
// m_axis carries the normalized bytes: tdata holds the byte and its 32-bit source
// index, tuser flags the end marker that closes each text with the total length in
// the index field, tlast flags the final result caused by one input byte.
// an accepted byte passes through the input register, then the result list register,
// before its first result shows.
// throughput: one input byte per cycle while m_axis_tready is high and each byte
// yields at most one result; a byte that yields k results holds the output list
// register until all k are taken, and the input register fills behind it. bytes
// that only extend a held sequence yield no result.
// reset: synchronous, clears held bytes, the position counter and pending results.
// when m_axis_tready is low the current result holds, the input register takes
// one more byte, then s_axis_tready drops until results drain.

module utf8_punctuation_to_ascii_unit #(
    parameter int INDEX_WIDTH = u2a_pkg::INDEX_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // in_byte
    input  logic                       s_axis_tlast,   // end_of_text
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [u2a_pkg::SRC_W+7:0]  m_axis_tdata,   // out_byte, source_index
    output logic                       m_axis_tuser,   // is_end_marker
    output logic                       m_axis_tlast    // last
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_eot_reg;
    logic               load_ok;
    logic               process;
    u2a_pkg::step_res_t res;

    assign process       = in_valid_reg && load_ok;
    assign s_axis_tready = !in_valid_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (process) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_eot_reg  <= s_axis_tlast;
        end
    end

    u2a_step #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (process),
        .in_byte (in_byte_reg),
        .in_eot  (in_eot_reg),
        .res     (res)
    );

    u2a_outq u_outq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (process),
        .res           (res),
        .load_ok       (load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> rtl/u2a_step.sv
`timescale 1ns / 1ps

module u2a_step #(
    parameter int INDEX_WIDTH = u2a_pkg::INDEX_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    input  logic                in_eot,
    output u2a_pkg::step_res_t  res
);

    localparam int SW = u2a_pkg::SRC_W;

    logic [7:0]             held0_reg, held0_next;
    logic [7:0]             held1_reg, held1_next;
    logic [1:0]             held_cnt_reg, held_cnt_next;
    logic [INDEX_WIDTH-1:0] idx0_reg, idx0_next;
    logic [INDEX_WIDTH-1:0] idx1_reg, idx1_next;
    logic [INDEX_WIDTH-1:0] pos_reg, pos_next;

    function automatic logic [SW-1:0] to_src(input logic [INDEX_WIDTH-1:0] v);
        return SW'(v);
    endfunction

    always_comb begin
        logic [INDEX_WIDTH-1:0]     pos_inc;
        u2a_pkg::rep_t              rep;
        logic                       take_b;
        u2a_pkg::item_list_t        lst;
        logic [u2a_pkg::CNT_W-1:0]  cnt;

        pos_inc       = (&pos_reg) ? pos_reg : pos_reg + 1'b1;
        rep           = '0;
        take_b        = 1'b0;
        lst           = '0;
        cnt           = '0;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        held_cnt_next = held_cnt_reg;
        idx0_next     = idx0_reg;
        idx1_next     = idx1_reg;

        case (held_cnt_reg)
            2'd0: begin
                take_b = 1'b1;
            end
            2'd1: begin
                rep = u2a_pkg::rep2(held0_reg, in_byte);
                if (!rep.hit) begin
                    if (u2a_pkg::is_prefix2(held0_reg, in_byte)) begin
                        held1_next    = in_byte;
                        idx1_next     = pos_reg;
                        held_cnt_next = 2'd2;
                    end else begin
                        lst[cnt] = u2a_pkg::mk_item(held0_reg, to_src(idx0_reg), 1'b0);
                        cnt      = cnt + 1'b1;
                        take_b   = 1'b1;
                    end
                end
            end
            default: begin
                rep = u2a_pkg::rep3(held0_reg, held1_reg, in_byte);
                if (!rep.hit) begin
                    // second held byte is never a lead byte, so it goes out as is
                    lst[cnt] = u2a_pkg::mk_item(held0_reg, to_src(idx0_reg), 1'b0);
                    cnt      = cnt + 1'b1;
                    lst[cnt] = u2a_pkg::mk_item(held1_reg, to_src(idx1_reg), 1'b0);
                    cnt      = cnt + 1'b1;
                    take_b   = 1'b1;
                end
            end
        endcase

        if (rep.hit) begin
            held_cnt_next = 2'd0;
            for (int k = 0; k < 4; k++) begin
                if (k < int'(rep.len)) begin
                    lst[cnt] = u2a_pkg::mk_item(rep.text[31-8*k -: 8], to_src(idx0_reg), 1'b0);
                    cnt      = cnt + 1'b1;
                end
            end
        end

        if (take_b) begin
            if (u2a_pkg::is_lead(in_byte)) begin
                held0_next    = in_byte;
                idx0_next     = pos_reg;
                held_cnt_next = 2'd1;
            end else begin
                held_cnt_next = 2'd0;
                lst[cnt] = u2a_pkg::mk_item(in_byte, to_src(pos_reg), 1'b0);
                cnt      = cnt + 1'b1;
            end
        end

        pos_next = pos_inc;
        if (in_eot) begin
            if (held_cnt_next != 2'd0) begin
                lst[cnt] = u2a_pkg::mk_item(held0_next, to_src(idx0_next), 1'b0);
                cnt      = cnt + 1'b1;
            end
            if (held_cnt_next == 2'd2) begin
                lst[cnt] = u2a_pkg::mk_item(held1_next, to_src(idx1_next), 1'b0);
                cnt      = cnt + 1'b1;
            end
            lst[cnt] = u2a_pkg::mk_item(8'd0, to_src(pos_inc), 1'b1);
            cnt      = cnt + 1'b1;
            held_cnt_next = 2'd0;
            pos_next      = '0;
        end

        res.items = lst;
        res.count = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt_reg <= 2'd0;
            pos_reg      <= '0;
        end else if (fire) begin
            held_cnt_reg <= held_cnt_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            idx0_reg  <= idx0_next;
            idx1_reg  <= idx1_next;
        end
    end

endmodule

>>> rtl/u2a_outq.sv
`timescale 1ns / 1ps

module u2a_outq (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      load,
    input  u2a_pkg::step_res_t                        res,
    output logic                                      load_ok,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [u2a_pkg::SRC_W+7:0]                 m_axis_tdata,
    output logic                                      m_axis_tuser,
    output logic                                      m_axis_tlast
);

    u2a_pkg::item_list_t        list_reg;
    logic [u2a_pkg::CNT_W-1:0]  cnt_reg;
    logic [u2a_pkg::CNT_W-1:0]  rd_reg;
    u2a_pkg::item_t             cur;
    logic                       at_last;
    logic                       xfer;

    assign cur           = list_reg[rd_reg];
    assign at_last       = (rd_reg == cnt_reg - 1'b1);
    assign m_axis_tvalid = (cnt_reg != '0);
    assign xfer          = m_axis_tvalid && m_axis_tready;
    assign load_ok       = (cnt_reg == '0) || (xfer && at_last);

    assign m_axis_tdata  = {cur.src, cur.data};
    assign m_axis_tuser  = cur.marker;
    assign m_axis_tlast  = at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (load) begin
            cnt_reg <= res.count;
            rd_reg  <= '0;
        end else if (xfer) begin
            if (at_last) begin
                cnt_reg <= '0;
            end else begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            list_reg <= res.items;
        end
    end

endmodule

>>> rtl/u2a_chk.sv
`timescale 1ns / 1ps

module u2a_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [u2a_pkg::SRC_W+7:0]  m_axis_tdata,
    input logic                       m_axis_tuser,
    input logic                       m_axis_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // end marker closes the results of its byte and carries a zero byte
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
        else $error("malformed end marker");

    // nothing pending right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // input is taken while the output is idle
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && $past(!m_axis_tvalid) && $past(aresetn) |-> s_axis_tready)
        else $error("input blocked with idle output");

endmodule

bind utf8_punctuation_to_ascii_unit u2a_chk u_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
